FILE: rtl/rrbc_pkg.sv
// Shared types, codes and constants of the receive ring boundary consumer.
package rrbc_pkg;

    localparam int PAGE_BITS    = 8;
    localparam int COUNT_BITS   = 16;
    localparam int LEN_BITS     = 11;
    localparam int ADDR_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 11;

    localparam int S_TDATA_BITS = 48;
    localparam int M_TDATA_BITS = 96;

    localparam logic [PAGE_BITS-1:0]  RESET_START_PAGE = 8'h46;
    localparam logic [PAGE_BITS-1:0]  RESET_STOP_PAGE  = 8'h80;
    localparam logic [LEN_BITS-1:0]   RESET_MAX_LENGTH = 11'd1518;
    localparam logic [COUNT_BITS-1:0] HEADER_BYTES     = 16'd4;
    localparam logic [COUNT_BITS-1:0] MIN_FRAME_BYTES  = 16'd14;

    typedef enum logic [2:0] {
        ST_EMPTY      = 3'd0,
        ST_FETCH      = 3'd1,
        ST_PACKET_OK  = 3'd2,
        ST_BAD_LINK   = 3'd3,
        ST_RUNT       = 3'd4,
        ST_BAD_LENGTH = 3'd5,
        ST_NO_PENDING = 3'd6
    } status_t;

    typedef enum logic {
        OP_POLL   = 1'b0,
        OP_HEADER = 1'b1
    } op_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RING_START = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RING_STOP  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LENGTH = 2'd2;

    typedef struct packed {
        logic [PAGE_BITS-1:0] ring_start_page;
        logic [PAGE_BITS-1:0] ring_stop_page;
        logic [LEN_BITS-1:0]  max_frame_length;
    } cfg_t;

    typedef struct packed {
        logic [PAGE_BITS-1:0] boundary;
        logic [PAGE_BITS-1:0] pending_page;
        logic [PAGE_BITS-1:0] latched_current;
        logic                 pending_valid;
    } ring_state_t;

    typedef struct packed {
        op_t                   op;
        logic [PAGE_BITS-1:0]  current_page;
        logic [PAGE_BITS-1:0]  hdr_next_page;
        logic [COUNT_BITS-1:0] hdr_byte_count;
        logic [COUNT_BITS-1:0] capacity;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [ADDR_BITS-1:0] header_address;
        logic [ADDR_BITS-1:0] first_address;
        logic [LEN_BITS-1:0]  first_length;
        logic [ADDR_BITS-1:0] second_address;
        logic [LEN_BITS-1:0]  second_length;
        logic [LEN_BITS-1:0]  delivered_length;
        logic                 clear_rx_flag;
        logic [PAGE_BITS-1:0] boundary_page;
    } result_t;

endpackage

FILE: rtl/rrbc_cfg_regs.sv
// Configuration register file of the receive ring boundary consumer.
module rrbc_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [rrbc_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [rrbc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output rrbc_pkg::cfg_t                     cfg
);
    import rrbc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_RING_START: cfg_next.ring_start_page  = cfg_wdata[PAGE_BITS-1:0];
                CFG_RING_STOP:  cfg_next.ring_stop_page   = cfg_wdata[PAGE_BITS-1:0];
                CFG_MAX_LENGTH: cfg_next.max_frame_length = cfg_wdata[LEN_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ring_start_page  <= RESET_START_PAGE;
            cfg_reg.ring_stop_page   <= RESET_STOP_PAGE;
            cfg_reg.max_frame_length <= RESET_MAX_LENGTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/rrbc_step.sv
// Combinational step logic: one item against the ring state gives a result and the next state.
module rrbc_step (
    input  rrbc_pkg::cfg_t        cfg,
    input  rrbc_pkg::ring_state_t state,
    input  rrbc_pkg::item_t       item,
    output rrbc_pkg::result_t     result,
    output rrbc_pkg::ring_state_t state_next
);
    import rrbc_pkg::*;

    logic [PAGE_BITS-1:0]  b_poll;
    logic [PAGE_BITS-1:0]  next_inc;
    logic [PAGE_BITS-1:0]  fetch_page;
    logic [PAGE_BITS-1:0]  back_curr;
    logic [PAGE_BITS-1:0]  back_link;
    logic [PAGE_BITS-1:0]  back_latched;
    logic                  link_outside;
    logic [COUNT_BITS-1:0] frame;
    logic [LEN_BITS-1:0]   len;
    logic [ADDR_BITS-1:0]  frame_addr;
    logic [ADDR_BITS-1:0]  stop_addr;
    logic [ADDR_BITS-1:0]  room;

    function automatic logic [PAGE_BITS-1:0] wrap_back(input logic [PAGE_BITS-1:0] page,
                                                       input cfg_t c);
        if (page <= c.ring_start_page) begin
            return c.ring_stop_page - 8'd1;
        end
        return page - 8'd1;
    endfunction

    function automatic logic outside_ring(input logic [PAGE_BITS-1:0] page, input cfg_t c);
        return (page < c.ring_start_page) || (page >= c.ring_stop_page);
    endfunction

    assign back_curr    = wrap_back(item.current_page, cfg);
    assign back_link    = wrap_back(item.hdr_next_page, cfg);
    assign back_latched = wrap_back(state.latched_current, cfg);
    assign link_outside = outside_ring(item.hdr_next_page, cfg);

    assign b_poll     = outside_ring(state.boundary, cfg) ? back_curr : state.boundary;
    assign next_inc   = b_poll + 8'd1;
    assign fetch_page = (next_inc >= cfg.ring_stop_page) ? cfg.ring_start_page : next_inc;

    assign frame      = item.hdr_byte_count - HEADER_BYTES;
    assign len        = (frame < item.capacity) ? frame[LEN_BITS-1:0]
                                                : item.capacity[LEN_BITS-1:0];
    assign frame_addr = {state.pending_page, HEADER_BYTES[7:0]};
    assign stop_addr  = {cfg.ring_stop_page, 8'h00};
    assign room       = (frame_addr < stop_addr) ? stop_addr - frame_addr : '0;

    always_comb begin
        result               = '0;
        result.status        = ST_EMPTY;
        state_next           = state;
        if (item.op == OP_POLL) begin
            state_next.pending_valid = 1'b0;
            state_next.boundary      = b_poll;
            priority if (fetch_page < cfg.ring_start_page) begin
                state_next.boundary = back_curr;
            end else if (fetch_page == item.current_page) begin
                result.clear_rx_flag = 1'b1;
            end else begin
                result.status              = ST_FETCH;
                result.header_address      = {fetch_page, 8'h00};
                state_next.pending_page    = fetch_page;
                state_next.latched_current = item.current_page;
                state_next.pending_valid   = 1'b1;
            end
        end else if (!state.pending_valid) begin
            result.status = ST_NO_PENDING;
        end else begin
            state_next.pending_valid = 1'b0;
            state_next.boundary      = back_link;
            priority if (link_outside) begin
                state_next.boundary = back_latched;
                result.status       = ST_BAD_LINK;
            end else if (item.hdr_byte_count < HEADER_BYTES) begin
                result.status        = ST_RUNT;
                result.clear_rx_flag = 1'b1;
            end else if ((frame < MIN_FRAME_BYTES) ||
                         (frame > {5'd0, cfg.max_frame_length})) begin
                result.status = ST_BAD_LENGTH;
            end else begin
                result.status           = ST_PACKET_OK;
                result.clear_rx_flag    = 1'b1;
                result.first_address    = frame_addr;
                result.second_address   = {cfg.ring_start_page, 8'h00};
                result.delivered_length = len;
                if ({5'd0, len} <= room) begin
                    result.first_length = len;
                end else begin
                    // Room is below the length here, so it fits the length width.
                    result.first_length  = room[LEN_BITS-1:0];
                    result.second_length = len - room[LEN_BITS-1:0];
                end
            end
        end
        result.boundary_page = state_next.boundary;
    end

endmodule

FILE: rtl/rx_ring_boundary_consumer_core.sv
// Top level of the receive ring boundary consumer: item register, step logic, result register.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  s_tuser op, s_tdata header and poll fields
//   m_        out        m_tvalid/m_tready  m_tuser status, m_tdata addresses and lengths
//   cfg_      in         cfg_we             cfg_addr register index, cfg_wdata value
//
// Every item passes the item register and then the result register on its way
// from acceptance to its result. The step logic between them is a few 8- and
// 16-bit compares and subtracts, so one item is accepted per cycle unless m_tready stalls the result.
// aresetn is synchronous and active low; it restores the register defaults,
// sets the boundary to the reset ring start and drops any pending header.
// A stalled result holds in the result register while the item register
// still takes one more item; the input stalls only when both are full.
module rx_ring_boundary_consumer_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // From bit 0: current_page[8], hdr_next_page[8], hdr_byte_count[16], capacity[16].
    input  logic [rrbc_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // From bit 0: op[1].
    input  logic                               s_tuser,
    // Result items.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // From bit 0: header_address[16], first_address[16], first_length[11],
    // second_address[16], second_length[11], delivered_length[11],
    // clear_rx_flag[1], boundary_page[8], zero fill[6].
    output logic [rrbc_pkg::M_TDATA_BITS-1:0]  m_tdata,
    // From bit 0: status[3].
    output logic [2:0]                         m_tuser,
    // Configuration writes.
    input  logic                               cfg_we,
    input  logic [rrbc_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [rrbc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
    import rrbc_pkg::*;

    cfg_t        cfg;
    ring_state_t state_reg;
    ring_state_t state_next;
    ring_state_t step_state;
    item_t       item_reg;
    item_t       s_item;
    logic        item_valid_reg;
    result_t     result_reg;
    result_t     step_result;
    logic        out_valid_reg;
    logic        advance;
    logic        s_accept;

    rrbc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Unpack the incoming item.
    assign s_item.op             = op_t'(s_tuser);
    assign s_item.current_page   = s_tdata[7:0];
    assign s_item.hdr_next_page  = s_tdata[15:8];
    assign s_item.hdr_byte_count = s_tdata[31:16];
    assign s_item.capacity       = s_tdata[47:32];

    // The held item moves into the result register whenever that register is free
    // or is being emptied in this cycle; the ring state updates in the same cycle,
    // so the next item always sees the state its predecessor left.
    assign advance  = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    rrbc_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .result     (step_result),
        .state_next (step_state)
    );

    assign state_next = advance ? step_state : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg            <= 1'b0;
            out_valid_reg             <= 1'b0;
            state_reg.boundary        <= RESET_START_PAGE;
            state_reg.pending_page    <= '0;
            state_reg.latched_current <= '0;
            state_reg.pending_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                item_valid_reg <= 1'b1;
            end else if (advance) begin
                item_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_item;
        end
        if (advance) begin
            result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tdata  = {6'd0,
                       result_reg.boundary_page,
                       result_reg.clear_rx_flag,
                       result_reg.delivered_length,
                       result_reg.second_length,
                       result_reg.second_address,
                       result_reg.first_length,
                       result_reg.first_address,
                       result_reg.header_address};

    // A pending header is only ever armed together with a fetch result.
    a_pending_from_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.pending_valid) |-> (out_valid_reg && result_reg.status == ST_FETCH))
        else $error("pending header armed without a fetch result");

    // The two read pieces of a good packet add up to the delivered length.
    a_split_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.status == ST_PACKET_OK) |->
        ({1'b0, result_reg.first_length} + {1'b0, result_reg.second_length} ==
         {1'b0, result_reg.delivered_length}))
        else $error("read split does not sum to delivered length");

    // Only a good packet reports a delivered length.
    a_len_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.status != ST_PACKET_OK) |->
        (result_reg.delivered_length == '0 && result_reg.second_length == '0))
        else $error("length reported on a result that is not a good packet");

endmodule

FILE: bench/tb_rx_ring_boundary_consumer_core.sv
// Self-checking testbench for rx_ring_boundary_consumer_core: directed and random ring traffic.
`timescale 1ns / 1ps

module tb_rx_ring_boundary_consumer_core;
    import rrbc_pkg::*;

    // A run with no item moving on either channel for this many cycles is hung.
    localparam int QUIET_LIMIT = 2000;
    // Items queued per random phase.
    localparam int PHASE_ITEMS = 80;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // From bit 0: current_page[8], hdr_next_page[8], hdr_byte_count[16], capacity[16].
    logic [S_TDATA_BITS-1:0]  s_tdata = '0;
    // From bit 0: op[1].
    logic                     s_tuser = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // From bit 0: header_address[16], first_address[16], first_length[11],
    // second_address[16], second_length[11], delivered_length[11],
    // clear_rx_flag[1], boundary_page[8], zero fill[6].
    logic [M_TDATA_BITS-1:0]  m_tdata;
    // From bit 0: status[3].
    logic [2:0]               m_tuser;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    rx_ring_boundary_consumer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Our own copy of the ring registers, updated whenever the bench writes one.
    logic [PAGE_BITS-1:0] rx_start;
    logic [PAGE_BITS-1:0] rx_stop;
    logic [LEN_BITS-1:0]  rx_max_len;

    // Tracked consumer state: boundary page, header page awaiting its header item,
    // the current page latched by that poll, and whether a header is awaited.
    logic [PAGE_BITS-1:0] bnd_page;
    logic [PAGE_BITS-1:0] hdr_page;
    logic [PAGE_BITS-1:0] hdr_cur_page;
    logic                 hdr_armed;

    item_t   queued_items[$];     // items waiting for the driver
    result_t awaited_results[$];  // predicted results in arrival order

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    logic        results_drained = 1'b1;

    function automatic logic off_ring(input logic [PAGE_BITS-1:0] pg);
        return pg < rx_start || pg >= rx_stop;
    endfunction

    // Page just behind pg, wrapping to the last ring page at or below the start.
    function automatic logic [PAGE_BITS-1:0] retreat_page(input logic [PAGE_BITS-1:0] pg);
        return (pg <= rx_start) ? rx_stop - 8'd1 : pg - 8'd1;
    endfunction

    // Works out the result of one item and advances the tracked state.
    function automatic result_t ring_consume_step(input item_t it);
        result_t r;
        logic [PAGE_BITS-1:0] b;
        logic [PAGE_BITS-1:0] nxt;
        int unsigned frame;
        int unsigned len;
        int unsigned addr;
        int unsigned stop_addr;
        int unsigned room;
        r = '0;
        r.status = ST_EMPTY;
        if (it.op == OP_POLL) begin
            // A poll always drops a header that was still awaited.
            hdr_armed = 1'b0;
            b = bnd_page;
            if (off_ring(b)) b = retreat_page(it.current_page);
            nxt = b + 8'd1;
            if (nxt >= rx_stop) nxt = rx_start;
            if (nxt < rx_start) begin
                b = retreat_page(it.current_page);
            end else if (nxt == it.current_page) begin
                r.clear_rx_flag = 1'b1;
            end else begin
                r.status = ST_FETCH;
                r.header_address = {nxt, 8'h00};
                hdr_page = nxt;
                hdr_cur_page = it.current_page;
                hdr_armed = 1'b1;
            end
            bnd_page = b;
        end else if (!hdr_armed) begin
            r.status = ST_NO_PENDING;
        end else begin
            hdr_armed = 1'b0;
            if (off_ring(it.hdr_next_page)) begin
                bnd_page = retreat_page(hdr_cur_page);
                r.status = ST_BAD_LINK;
            end else if (it.hdr_byte_count < HEADER_BYTES) begin
                bnd_page = retreat_page(it.hdr_next_page);
                r.status = ST_RUNT;
                r.clear_rx_flag = 1'b1;
            end else begin
                frame = it.hdr_byte_count - HEADER_BYTES;
                bnd_page = retreat_page(it.hdr_next_page);
                if (frame < MIN_FRAME_BYTES || frame > rx_max_len) begin
                    r.status = ST_BAD_LENGTH;
                end else begin
                    len = (frame < it.capacity) ? frame : it.capacity;
                    addr = hdr_page * 256 + 4;
                    stop_addr = rx_stop * 256;
                    // The frame may start at or past the ring end when the ring
                    // shrank after the poll; then all of it lands in the wrapped part.
                    room = (addr < stop_addr) ? stop_addr - addr : 0;
                    r.first_address = 16'(addr);
                    r.second_address = {rx_start, 8'h00};
                    if (len <= room) begin
                        r.first_length = 11'(len);
                    end else begin
                        r.first_length = 11'(room);
                        r.second_length = 11'(len - room);
                    end
                    r.delivered_length = 11'(len);
                    r.status = ST_PACKET_OK;
                    r.clear_rx_flag = 1'b1;
                end
            end
        end
        r.boundary_page = bnd_page;
        return r;
    endfunction

    // Driver: presents queued items, holding each one until it is accepted.
    // After its 50th item and every 97 items after that it also stops and waits until all results are back.
    always @(posedge aclk) begin : drive_items
        item_t       next_item;
        int unsigned issued;
        logic        drain_hold;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            issued = 0;
            drain_hold = 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (drain_hold && !s_tvalid && results_drained) drain_hold = 1'b0;
            if (!drain_hold && queued_items.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                next_item = queued_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_item.op;
                s_tdata <= {next_item.capacity, next_item.hdr_byte_count,
                            next_item.hdr_next_page, next_item.current_page};
                issued++;
                if (issued % 97 == 50) drain_hold = 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Monitor: predicts on every accepted input item, then checks every
    // accepted result against the oldest prediction. Predicting first keeps
    // the outcome independent of the block's latency.
    always @(posedge aclk) begin : check_results
        item_t   taken;
        result_t seen;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken.op = op_t'(s_tuser);
                taken.current_page = s_tdata[7:0];
                taken.hdr_next_page = s_tdata[15:8];
                taken.hdr_byte_count = s_tdata[31:16];
                taken.capacity = s_tdata[47:32];
                awaited_results.push_back(ring_consume_step(taken));
            end
            if (m_tvalid && m_tready) begin
                seen.status = status_t'(m_tuser);
                seen.header_address = m_tdata[15:0];
                seen.first_address = m_tdata[31:16];
                seen.first_length = m_tdata[42:32];
                seen.second_address = m_tdata[58:43];
                seen.second_length = m_tdata[69:59];
                seen.delivered_length = m_tdata[80:70];
                seen.clear_rx_flag = m_tdata[81];
                seen.boundary_page = m_tdata[89:82];
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with no expectation waiting, status %0d",
                             $time, m_tuser);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", want.status, seen.status);
                    compare_field("header_address", want.header_address, seen.header_address);
                    compare_field("first_address", want.first_address, seen.first_address);
                    compare_field("first_length", want.first_length, seen.first_length);
                    compare_field("second_address", want.second_address, seen.second_address);
                    compare_field("second_length", want.second_length, seen.second_length);
                    compare_field("delivered_length", want.delivered_length,
                                  seen.delivered_length);
                    compare_field("clear_rx_flag", want.clear_rx_flag, seen.clear_rx_flag);
                    compare_field("boundary_page", want.boundary_page, seen.boundary_page);
                    compare_field("zero fill", 0, m_tdata[95:90]);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
        results_drained <= (awaited_results.size() == 0);
    end

    // Watchdog: ends the run when neither channel has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic push_poll(input logic [PAGE_BITS-1:0] cur_pg);
        item_t it;
        it.op = OP_POLL;
        it.current_page = cur_pg;
        it.hdr_next_page = 8'($urandom);
        it.hdr_byte_count = 16'($urandom);
        it.capacity = 16'($urandom);
        queued_items.push_back(it);
    endtask

    task automatic push_header(input logic [PAGE_BITS-1:0] link, input logic [15:0] count,
                               input logic [15:0] cap);
        item_t it;
        it.op = OP_HEADER;
        it.current_page = 8'($urandom);
        it.hdr_next_page = link;
        it.hdr_byte_count = count;
        it.capacity = cap;
        queued_items.push_back(it);
    endtask

    // Mostly well-formed poll and header pairs for the current ring, with some
    // broken headers, lone polls and fully random items mixed in.
    task automatic queue_random(input int unsigned count);
        int unsigned made;
        int unsigned pick;
        int unsigned frame;
        logic [PAGE_BITS-1:0] link;
        logic [15:0] cap;
        logic [15:0] bad_count;
        item_t it;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (rx_stop > rx_start) link = 8'($urandom_range(rx_stop - 1, rx_start));
            else link = 8'($urandom);
            case ($urandom_range(9))
                0: frame = MIN_FRAME_BYTES;
                1: frame = rx_max_len;
                default: frame = $urandom_range(rx_max_len, MIN_FRAME_BYTES);
            endcase
            if ($urandom_range(1) == 1) cap = 16'($urandom_range(65535, 1));
            else cap = 16'($urandom_range(2047, 1));
            if (pick < 65) begin
                push_poll(8'($urandom));
                push_header(link, 16'(frame + 4), cap);
                made += 2;
            end else if (pick < 75) begin
                push_poll(8'($urandom));
                bad_count = 16'(frame + 4);
                case ($urandom_range(3))
                    0: link = 8'($urandom);
                    1: bad_count = 16'($urandom_range(3, 0));
                    2: bad_count = 16'($urandom_range(17, 4));
                    default: bad_count = 16'($urandom_range(65535, rx_max_len + 5));
                endcase
                push_header(link, bad_count, cap);
                made += 2;
            end else if (pick < 85) begin
                push_poll(8'($urandom));
                made++;
            end else begin
                it.op = op_t'($urandom_range(1));
                it.current_page = 8'($urandom);
                it.hdr_next_page = 8'($urandom);
                it.hdr_byte_count = 16'($urandom);
                it.capacity = 16'($urandom);
                queued_items.push_back(it);
                made++;
            end
        end
    endtask

    // Returns once every queued item went in and every result came back,
    // then waits for the block's two-stage pipeline to settle.
    task automatic wait_idle();
        do @(negedge aclk);
        while (queued_items.size() != 0 || s_tvalid || !results_drained);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_RING_START: rx_start = value[7:0];
            CFG_RING_STOP:  rx_stop = value[7:0];
            CFG_MAX_LENGTH: rx_max_len = value;
            default: ;
        endcase
    endtask

    task automatic set_ring(input logic [PAGE_BITS-1:0] first_pg,
                            input logic [PAGE_BITS-1:0] stop_pg,
                            input logic [LEN_BITS-1:0] max_len);
        write_reg(CFG_RING_START, {3'b000, first_pg});
        write_reg(CFG_RING_STOP, {3'b000, stop_pg});
        write_reg(CFG_MAX_LENGTH, max_len);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int unsigned p;
        int unsigned first_pg;
        rx_start = RESET_START_PAGE;
        rx_stop = RESET_STOP_PAGE;
        rx_max_len = RESET_MAX_LENGTH;
        bnd_page = RESET_START_PAGE;
        hdr_page = '0;
        hdr_cur_page = '0;
        hdr_armed = 1'b0;

        // Directed part on the reset ring, pages 0x46 up to 0x7F. The comments
        // give the outcome intended from the state the previous items leave.
        push_header(8'h50, 16'd68, 16'd100);        // header with no poll before it
        push_poll(8'h00);                           // fetch at the page after the boundary
        push_poll(8'hFF);                           // a second poll replaces the first
        push_header(8'h50, 16'd68, 16'hFFFF);       // good packet
        push_poll(8'h50);                           // next page equals current: empty
        push_poll(8'h60);
        push_header(8'h20, 16'd68, 16'd100);        // link below the ring
        push_poll(8'h70);
        push_header(8'h61, 16'd3, 16'd100);         // byte count too small for a header
        push_poll(8'h70);
        push_header(8'h62, 16'd17, 16'd100);        // frame one byte short of the minimum
        push_poll(8'h70);
        push_header(8'h63, 16'd1523, 16'd100);      // frame one byte over the maximum
        push_poll(8'h70);
        push_header(8'h7F, 16'd1522, 16'd0);        // largest frame, zero capacity
        push_poll(8'h10);                           // header sits in the last ring page
        push_header(8'h46, 16'd1004, 16'd1000);     // read splits at the ring end
        push_poll(8'h47);                           // boundary at the end wraps to start
        push_header(8'hFF, 16'hFFFF, 16'hFFFF);     // all-ones link is off the ring
        push_poll(8'h00);
        push_header(8'h7F, 16'd18, 16'hFFFF);       // smallest frame
        push_poll(8'h46);                           // leaves a header awaited at 0x7F

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        // Random phases. Each one writes all three registers while the block is
        // idle and uses its own idling pattern, cycling through none, sender
        // idle, receiver stalling and both.
        for (p = 0; p < 8; p++) begin
            first_pg = $urandom_range(250, 1);
            case (p)
                // Shrink the ring under the awaited header so the frame starts past
                // the new ring end, and leave the boundary outside the ring.
                0: set_ring(8'h46, 8'h60, RESET_MAX_LENGTH);
                1: set_ring(8'd1, 8'd255, 11'd2047);
                2: set_ring(8'd254, 8'd255, 11'd14);
                3: set_ring(8'd1, 8'd2, 11'd14);
                // Stop page below the start page.
                4: set_ring(8'd200, 8'd100, 11'd600);
                7: set_ring(RESET_START_PAGE, RESET_STOP_PAGE, RESET_MAX_LENGTH);
                default: set_ring(8'(first_pg), 8'($urandom_range(255, first_pg + 1)),
                                  11'($urandom_range(2047, 14)));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            if (p == 0) push_header(8'h50, 16'd104, 16'd2000);
            queue_random(PHASE_ITEMS);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: rx_ring_boundary_consumer_core.f
rtl/rrbc_pkg.sv
rtl/rrbc_cfg_regs.sv
rtl/rrbc_step.sv
rtl/rx_ring_boundary_consumer_core.sv
bench/tb_rx_ring_boundary_consumer_core.sv
